@@ design/efla_pkg.sv @@
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types, constants and helper functions for the free-list allocator.
// ----------------------------------------------------------------------------
package efla_pkg;

    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int CHUNK_BYTES_DEF = 16;
    localparam int MIN_BLOCK       = 24;

    localparam logic [31:0] SIZE_MASK  = 32'hFFFF_FFF8;
    localparam logic [31:0] PROLOGUE   = 32'd8;
    localparam logic [31:0] INIT_BASE  = 32'd48;
    localparam logic [31:0] PRO_TAG    = 32'd25;
    localparam logic [31:0] EPI_TAG    = 32'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [31:0] addr;
        logic [31:0] wdata;
    } mem_req_t;

    // Growth size in bytes for a word count: round to even words, floor at MIN_BLOCK.
    function automatic logic [31:0] grow_size(input logic [31:0] words);
        logic [31:0] w;
        logic [31:0] b;
        begin
            w = words + {31'd0, words[0]};
            b = w << 2;
            grow_size = (b < 32'(MIN_BLOCK)) ? 32'(MIN_BLOCK) : b;
        end
    endfunction

    function automatic logic word_in_store(input logic [31:0] a, input logic [31:0] words);
        word_in_store = ({2'b00, a[31:2]} < words);
    endfunction

    // Contents of the heap right after reset, by word index.
    function automatic logic [31:0] init_word(input logic [31:0] idx,
                                              input logic        fits,
                                              input logic [31:0] bsize);
        logic [31:0] a;
        begin
            a = idx << 2;
            if (a == 32'd4 || a == 32'd24)
                init_word = PRO_TAG;
            else if (a == 32'd28)
                init_word = EPI_TAG;
            else if (fits && a == PROLOGUE)
                init_word = INIT_BASE;
            else if (fits && a == INIT_BASE - 32'd4)
                init_word = bsize;
            else if (fits && a == INIT_BASE + 32'd8)
                init_word = PROLOGUE;
            else if (fits && a == INIT_BASE + bsize - 32'd8)
                init_word = bsize;
            else if (fits && a == INIT_BASE + bsize - 32'd4)
                init_word = EPI_TAG;
            else
                init_word = 32'd0;
        end
    endfunction

endpackage

@@ design/efla_heap_ram.sv @@
// ----------------------------------------------------------------------------
// efla_heap_ram
// Single-port heap word store, byte addressed, registered read.
// ----------------------------------------------------------------------------
module efla_heap_ram
    import efla_pkg::*;
#(
    parameter int HEAP_WORDS = HEAP_BYTES_DEF / 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output logic [31:0] rdata
);

    localparam int IW = $clog2(HEAP_WORDS);

    logic [31:0] mem [HEAP_WORDS];
    logic [31:0] q_reg;
    logic        hit_reg;
    logic        in_range;
    logic [IW-1:0] idx;

    assign in_range = word_in_store(req.addr, 32'(HEAP_WORDS));
    assign idx      = req.addr[IW+1:2];

    always_ff @(posedge clk)
    begin
        if (req.wr && in_range)
        begin
            mem[idx] <= req.wdata;
        end
        if (req.rd && in_range)
        begin
            q_reg <= mem[idx];
        end
    end

    // Out-of-store reads answer zero; hold the flag with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (req.rd)
        begin
            hit_reg <= in_range;
        end
    end

    assign rdata = hit_reg ? q_reg : 32'd0;

endmodule

@@ design/efla_engine.sv @@
// ----------------------------------------------------------------------------
// efla_engine
// Sequencer for allocate and release: list walk, split, coalesce, growth.
// ----------------------------------------------------------------------------
module efla_engine
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        command,
    input  logic [15:0] request_size,
    input  logic [15:0] block_address,
    output logic        busy,
    output logic        done,
    output logic [15:0] result_address,
    output logic [1:0]  status,
    output mem_req_t    mem_req,
    input  logic [31:0] mem_rdata
);

    localparam int          HEAP_WORDS = HEAP_BYTES / 4;
    localparam int          WALK_LIMIT = HEAP_BYTES / 8;
    localparam int          WW         = $clog2(WALK_LIMIT + 1);
    localparam logic [31:0] INIT_SIZE  = grow_size(32'(CHUNK_BYTES) >> 2);
    localparam logic        INIT_FITS  = (33'(INIT_BASE) + 33'(INIT_SIZE)) <= 33'(HEAP_BYTES);
    localparam logic [31:0] HEAD_RST   = INIT_FITS ? INIT_BASE : PROLOGUE;
    localparam logic [31:0] TOP_RST    = INIT_FITS ? INIT_BASE + INIT_SIZE : INIT_BASE;

    typedef enum logic [5:0] {
        S_IDLE, S_FF_RD, S_FF_CHK, S_FF_NEXT, S_GROW, S_GR_EPI, S_GR_END,
        S_TK_DEC, S_TK_S1, S_TK_S2, S_TK_S3, S_TK_N1, S_TK_FIN,
        S_RL_RD, S_RL_ST, S_RL_FIN,
        S_ST_H, S_ST_F,
        S_RM_0, S_RM_1, S_RM_2, S_RM_3, S_RM_4, S_RM_5,
        S_MG_0, S_MG_1, S_MG_2, S_MG_3, S_MG_4, S_MG_5,
        S_MG_C1, S_MG_C2, S_MG_C3, S_MG_C4, S_MG_TAGS,
        S_MG_INS, S_MG_I2, S_MG_I3
    } state_t;

    state_t        state_reg;
    state_t        st_ret_reg;
    state_t        rm_ret_reg;
    state_t        mg_ret_reg;
    logic [31:0]   head_reg;
    logic [31:0]   top_reg;
    logic [WW-1:0] walk_reg;
    logic [16:0]   asize_reg;
    logic [31:0]   bp_reg;
    logic [31:0]   csize_reg;
    logic [31:0]   st_bp_reg;
    logic [31:0]   st_size_reg;
    logic          st_alloc_reg;
    logic [31:0]   rm_bp_reg;
    logic [31:0]   rm_p_reg;
    logic [31:0]   rm_y_reg;
    logic [31:0]   mg_bp_reg;
    logic [31:0]   pb_reg;
    logic [31:0]   nb_reg;
    logic [31:0]   size_reg;
    logic [31:0]   psz_reg;
    logic          prev_alloc_reg;
    logic          done_reg;
    logic [15:0]   result_address_reg;
    logic [1:0]    status_reg;

    logic [31:0] dm;
    logic [16:0] asize_in;
    logic [16:0] asize_rnd;
    logic [31:0] ext;
    logic [31:0] gsize;
    logic        grow_fail;
    logic [31:0] hdr_addr;
    logic [31:0] hsz;
    logic        fit;
    logic        split;

    assign dm        = mem_rdata & SIZE_MASK;
    assign asize_rnd = ((17'(request_size) + 17'd7) & 17'h1FFF8) + 17'd8;
    assign asize_in  = (asize_rnd < 17'(MIN_BLOCK)) ? 17'(MIN_BLOCK) : asize_rnd;
    assign ext       = (32'(asize_reg) > 32'(CHUNK_BYTES)) ? 32'(asize_reg) : 32'(CHUNK_BYTES);
    assign gsize     = grow_size(ext >> 2);
    assign grow_fail = (33'(top_reg) + 33'(gsize)) > 33'(HEAP_BYTES);
    assign hdr_addr  = st_bp_reg - 32'd4;
    assign hsz       = word_in_store(hdr_addr, 32'(HEAP_WORDS)) ? (st_size_reg & SIZE_MASK)
                                                                : 32'd0;
    assign fit       = 32'(asize_reg) <= dm;
    assign split     = (dm >= 32'(asize_reg)) && (dm - 32'(asize_reg) >= 32'(MIN_BLOCK));

    // At most one memory access per state.
    always_comb
    begin
        mem_req = '0;
        unique case (state_reg)
            S_FF_RD:
            begin
                mem_req.rd   = (walk_reg != WW'(WALK_LIMIT));
                mem_req.addr = bp_reg - 32'd4;
            end
            S_FF_CHK:
            begin
                mem_req.rd   = !mem_rdata[0] && !fit;
                mem_req.addr = bp_reg + 32'd8;
            end
            S_GR_END:
            begin
                mem_req.rd   = (mg_bp_reg != 32'd0);
                mem_req.addr = mg_bp_reg - 32'd4;
            end
            S_TK_S2, S_RL_RD:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = bp_reg - 32'd4;
            end
            S_ST_H:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = hdr_addr;
                mem_req.wdata = st_size_reg | {31'd0, st_alloc_reg};
            end
            S_ST_F:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = st_bp_reg + hsz - 32'd8;
                mem_req.wdata = st_size_reg | {31'd0, st_alloc_reg};
            end
            S_GR_EPI:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = mg_bp_reg + st_size_reg - 32'd4;
                mem_req.wdata = EPI_TAG;
            end
            S_RM_0, S_RM_4:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = rm_bp_reg;
            end
            S_RM_1, S_RM_3:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = rm_bp_reg + 32'd8;
            end
            S_RM_2:
            begin
                mem_req.wr    = (rm_p_reg != 32'd0);
                mem_req.addr  = rm_p_reg + 32'd8;
                mem_req.wdata = mem_rdata;
            end
            S_RM_5:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = rm_y_reg;
                mem_req.wdata = mem_rdata;
            end
            S_MG_0, S_MG_C3:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = mg_bp_reg - 32'd8;
            end
            S_MG_1:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = mg_bp_reg - dm - 32'd4;
            end
            S_MG_2:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = pb_reg + dm - 32'd8;
            end
            S_MG_3, S_MG_C1:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = mg_bp_reg - 32'd4;
            end
            S_MG_4:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = mg_bp_reg + dm - 32'd4;
            end
            S_MG_INS:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = mg_bp_reg + 32'd8;
                mem_req.wdata = head_reg;
            end
            S_MG_I2:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = head_reg;
                mem_req.wdata = mg_bp_reg;
            end
            S_MG_I3:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = mg_bp_reg;
                mem_req.wdata = 32'd0;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            st_ret_reg         <= S_IDLE;
            rm_ret_reg         <= S_IDLE;
            mg_ret_reg         <= S_IDLE;
            head_reg           <= HEAD_RST;
            top_reg            <= TOP_RST;
            walk_reg           <= '0;
            done_reg           <= 1'b0;
            result_address_reg <= 16'd0;
            status_reg         <= STATUS_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        result_address_reg <= 16'd0;
                        status_reg         <= STATUS_OK;
                        bp_reg             <= head_reg;
                        walk_reg           <= '0;
                        asize_reg          <= asize_in;
                        if (command == CMD_ALLOC)
                        begin
                            if (request_size == 16'd0)
                            begin
                                status_reg <= STATUS_ZERO;
                                done_reg   <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_FF_RD;
                            end
                        end
                        else if (block_address == 16'd0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            bp_reg    <= 32'(block_address);
                            state_reg <= S_RL_RD;
                        end
                    end
                end
                S_FF_RD:
                begin
                    state_reg <= (walk_reg == WW'(WALK_LIMIT)) ? S_GROW : S_FF_CHK;
                end
                S_FF_CHK:
                begin
                    if (mem_rdata[0])
                        state_reg <= S_GROW;
                    else if (fit)
                        state_reg <= (bp_reg == 32'd0) ? S_GROW : S_TK_DEC;
                    else
                        state_reg <= S_FF_NEXT;
                end
                S_FF_NEXT:
                begin
                    bp_reg    <= mem_rdata;
                    walk_reg  <= walk_reg + 1'b1;
                    state_reg <= S_FF_RD;
                end
                S_GROW:
                begin
                    if (grow_fail)
                    begin
                        status_reg <= STATUS_FULL;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        mg_bp_reg    <= top_reg;
                        top_reg      <= top_reg + gsize;
                        st_bp_reg    <= top_reg;
                        st_size_reg  <= gsize;
                        st_alloc_reg <= 1'b0;
                        st_ret_reg   <= S_GR_EPI;
                        state_reg    <= S_ST_H;
                    end
                end
                S_GR_EPI:
                begin
                    mg_ret_reg <= S_GR_END;
                    state_reg  <= S_MG_0;
                end
                S_GR_END:
                begin
                    if (mg_bp_reg == 32'd0)
                    begin
                        status_reg <= STATUS_FULL;
                        done_reg   <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        bp_reg    <= mg_bp_reg;
                        state_reg <= S_TK_DEC;
                    end
                end
                S_TK_DEC:
                begin
                    csize_reg    <= dm;
                    st_bp_reg    <= bp_reg;
                    st_alloc_reg <= 1'b1;
                    st_size_reg  <= split ? 32'(asize_reg) : dm;
                    st_ret_reg   <= split ? S_TK_S1 : S_TK_N1;
                    state_reg    <= S_ST_H;
                end
                S_TK_S1:
                begin
                    rm_bp_reg  <= bp_reg;
                    rm_ret_reg <= S_TK_S2;
                    state_reg  <= S_RM_0;
                end
                S_TK_S2:
                begin
                    state_reg <= S_TK_S3;
                end
                S_TK_S3:
                begin
                    mg_bp_reg    <= bp_reg + dm;
                    st_bp_reg    <= bp_reg + dm;
                    st_size_reg  <= csize_reg - 32'(asize_reg);
                    st_alloc_reg <= 1'b0;
                    st_ret_reg   <= S_MG_0;
                    mg_ret_reg   <= S_TK_FIN;
                    state_reg    <= S_ST_H;
                end
                S_TK_N1:
                begin
                    rm_bp_reg  <= bp_reg;
                    rm_ret_reg <= S_TK_FIN;
                    state_reg  <= S_RM_0;
                end
                S_TK_FIN:
                begin
                    result_address_reg <= bp_reg[15:0];
                    done_reg           <= 1'b1;
                    state_reg          <= S_IDLE;
                end
                S_RL_RD:
                begin
                    state_reg <= S_RL_ST;
                end
                S_RL_ST:
                begin
                    st_bp_reg    <= bp_reg;
                    st_size_reg  <= dm;
                    st_alloc_reg <= 1'b0;
                    st_ret_reg   <= S_MG_0;
                    mg_bp_reg    <= bp_reg;
                    mg_ret_reg   <= S_RL_FIN;
                    state_reg    <= S_ST_H;
                end
                S_RL_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_ST_H:
                begin
                    state_reg <= S_ST_F;
                end
                S_ST_F:
                begin
                    state_reg <= st_ret_reg;
                end
                S_RM_0:
                begin
                    state_reg <= S_RM_1;
                end
                S_RM_1:
                begin
                    rm_p_reg  <= mem_rdata;
                    state_reg <= S_RM_2;
                end
                S_RM_2:
                begin
                    if (rm_p_reg == 32'd0)
                        head_reg <= mem_rdata;
                    state_reg <= S_RM_3;
                end
                S_RM_3:
                begin
                    state_reg <= S_RM_4;
                end
                S_RM_4:
                begin
                    rm_y_reg  <= mem_rdata;
                    state_reg <= S_RM_5;
                end
                S_RM_5:
                begin
                    state_reg <= rm_ret_reg;
                end
                S_MG_0:
                begin
                    state_reg <= S_MG_1;
                end
                S_MG_1:
                begin
                    pb_reg    <= mg_bp_reg - dm;
                    state_reg <= S_MG_2;
                end
                S_MG_2:
                begin
                    psz_reg   <= dm;
                    state_reg <= S_MG_3;
                end
                S_MG_3:
                begin
                    prev_alloc_reg <= mem_rdata[0] || (pb_reg == mg_bp_reg);
                    state_reg      <= S_MG_4;
                end
                S_MG_4:
                begin
                    size_reg  <= dm;
                    nb_reg    <= mg_bp_reg + dm;
                    state_reg <= S_MG_5;
                end
                S_MG_5:
                begin
                    priority if (prev_alloc_reg && mem_rdata[0])
                    begin
                        state_reg <= S_MG_INS;
                    end
                    else if (prev_alloc_reg)
                    begin
                        size_reg   <= size_reg + dm;
                        rm_bp_reg  <= nb_reg;
                        rm_ret_reg <= S_MG_TAGS;
                        state_reg  <= S_RM_0;
                    end
                    else if (mem_rdata[0])
                    begin
                        size_reg   <= size_reg + psz_reg;
                        mg_bp_reg  <= pb_reg;
                        rm_bp_reg  <= pb_reg;
                        rm_ret_reg <= S_MG_TAGS;
                        state_reg  <= S_RM_0;
                    end
                    else
                    begin
                        size_reg   <= size_reg + psz_reg + dm;
                        rm_bp_reg  <= pb_reg;
                        rm_ret_reg <= S_MG_C1;
                        state_reg  <= S_RM_0;
                    end
                end
                S_MG_C1:
                begin
                    state_reg <= S_MG_C2;
                end
                S_MG_C2:
                begin
                    // Re-read the size: the first unlink may have touched it.
                    rm_bp_reg  <= mg_bp_reg + dm;
                    rm_ret_reg <= S_MG_C3;
                    state_reg  <= S_RM_0;
                end
                S_MG_C3:
                begin
                    state_reg <= S_MG_C4;
                end
                S_MG_C4:
                begin
                    mg_bp_reg <= mg_bp_reg - dm;
                    state_reg <= S_MG_TAGS;
                end
                S_MG_TAGS:
                begin
                    st_bp_reg    <= mg_bp_reg;
                    st_size_reg  <= size_reg;
                    st_alloc_reg <= 1'b0;
                    st_ret_reg   <= S_MG_INS;
                    state_reg    <= S_ST_H;
                end
                S_MG_INS:
                begin
                    state_reg <= S_MG_I2;
                end
                S_MG_I2:
                begin
                    state_reg <= S_MG_I3;
                end
                S_MG_I3:
                begin
                    head_reg  <= mg_bp_reg;
                    state_reg <= mg_ret_reg;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign result_address = result_address_reg;
    assign status         = status_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while sequencer active");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != STATUS_OK) |-> result_address_reg == 16'd0)
        else $error("failure carries nonzero address");
    a_top_cap: assert property (@(posedge clk) disable iff (!rst_n)
        33'(top_reg) <= 33'(HEAP_BYTES))
        else $error("heap top beyond capacity");
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd && mem_req.wr))
        else $error("read and write in one cycle");
    a_start_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start) |=> (done_reg || state_reg != S_IDLE))
        else $error("accepted item dropped");
`endif

endmodule

@@ design/explicit_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// explicit_free_list_allocator
// Boundary-tag heap allocator with a LIFO explicit free list and first fit.
// ----------------------------------------------------------------------------
// Raise start with command and its fields while busy is low; the item is
// taken on that edge. Exactly one result follows: done is high for one cycle
// with result_address and status, and it cannot be held off, so sample it
// then. The heap contents live in one single-port word memory, one access
// per cycle, and that port sets the pace; the free-list head and the heap
// top are registers. An allocate walks the free list link by link, then
// takes the block, splitting it when the remainder is large enough and
// coalescing the remainder with a free block above it where there is one;
// if no block fits, the heap grows and the new chunk goes through a
// coalescing pass. A release merges the block with its free neighbors. A
// zero-size allocate or a release of address 0 answers on the next cycle.
// After reset, busy stays high while the initial heap layout is written,
// one word a cycle.
// ----------------------------------------------------------------------------
module explicit_free_list_allocator
    import efla_pkg::*;
#(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [15:0] request_size,
    input  logic [15:0] block_address,
    output logic        done,
    output logic [15:0] result_address,
    output logic [1:0]  status
);

    // Layout written at reset: prologue, epilogue and the first free chunk.
    localparam logic [31:0] INIT_SIZE  = grow_size(32'(CHUNK_BYTES) >> 2);
    localparam logic        INIT_FITS  = (33'(INIT_BASE) + 33'(INIT_SIZE)) <= 33'(HEAP_BYTES);
    localparam int          INIT_WORDS = INIT_FITS ? int'((INIT_BASE + INIT_SIZE) >> 2) : 12;
    localparam int          CW         = $clog2(INIT_WORDS + 1);

    logic [CW-1:0] init_cnt_reg;
    logic          init_reg;
    logic          eng_busy;
    mem_req_t      eng_req;
    mem_req_t      ram_req;
    logic [31:0]   ram_rdata;

    // Sweep the init layout into the memory, one word a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg <= '0;
            init_reg     <= 1'b1;
        end
        else if (init_reg)
        begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
            if (init_cnt_reg == CW'(INIT_WORDS - 1))
            begin
                init_reg <= 1'b0;
            end
        end
    end

    // Hand the memory port to the sweep until it is done.
    always_comb
    begin
        if (init_reg)
        begin
            ram_req.rd    = 1'b0;
            ram_req.wr    = 1'b1;
            ram_req.addr  = 32'(init_cnt_reg) << 2;
            ram_req.wdata = init_word(32'(init_cnt_reg), INIT_FITS, INIT_SIZE);
        end
        else
        begin
            ram_req = eng_req;
        end
    end

    efla_heap_ram #(
        .HEAP_WORDS (HEAP_BYTES / 4)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    efla_engine #(
        .HEAP_BYTES  (HEAP_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start && !init_reg),
        .command        (command),
        .request_size   (request_size),
        .block_address  (block_address),
        .busy           (eng_busy),
        .done           (done),
        .result_address (result_address),
        .status         (status),
        .mem_req        (eng_req),
        .mem_rdata      (ram_rdata)
    );

    // Hold off new items during the sweep and while an item is in work.
    assign busy = init_reg || eng_busy;

endmodule
